>>> design/first_fit_heap_allocator_defines.svh
// Assertion macros for the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define FFHA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("ffha assertion failed");
// Check that a condition never holds outside reset.
`define FFHA_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ffha forbidden condition");
`else
`define FFHA_ASSERT(lbl, clk, rst, prop)
`define FFHA_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> design/ffha_pkg.sv
package ffha_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 24;
  // Alignment must stay a power of two; rounding is done with a mask.
  localparam int ALIGN_BYTES  = 16;
  localparam int ALIGN_LOG    = $clog2(ALIGN_BYTES);

  localparam int ADDR_W = 48;
  localparam int SIZE_W = 25;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT  = 2'd1;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

  localparam logic ACTION_ALLOC   = 1'b0;
  localparam logic ACTION_RELEASE = 1'b1;

  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_BYTES = 1'b1;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_bytes;
    logic [ADDR_W-1:0] payload_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
  } resp_t;

  // Block table entry without the link field.
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } entry_t;

endpackage

>>> design/ffha_mem.sv
module ffha_mem #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS,
  parameter int IW = $clog2(MAX_BLOCKS),
  parameter int NW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IW-1:0]    waddr,
  input  ffha_pkg::entry_t wentry,
  input  logic [NW-1:0]    wnext,
  input  logic             re,
  input  logic [IW-1:0]    raddr,
  output ffha_pkg::entry_t rentry,
  output logic [NW-1:0]    rnext
);

  ffha_pkg::entry_t entries [MAX_BLOCKS];
  logic [NW-1:0]    links   [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      entries[waddr] <= wentry;
      links[waddr]   <= wnext;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rentry <= entries[raddr];
      rnext  <= links[raddr];
    end
  end

endmodule

>>> design/ffha_ctrl.sv
`include "first_fit_heap_allocator_defines.svh"
module ffha_ctrl #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS,
  parameter int IW = $clog2(MAX_BLOCKS),
  parameter int NW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        reinit,
  input  logic [ffha_pkg::ADDR_W-1:0] start_addr,
  input  logic [ffha_pkg::SIZE_W-1:0] first_size,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ffha_pkg::req_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ffha_pkg::resp_t             out_data,
  output logic                        we,
  output logic [IW-1:0]               waddr,
  output ffha_pkg::entry_t            wentry,
  output logic [NW-1:0]               wnext,
  output logic                        re,
  output logic [IW-1:0]               raddr,
  input  ffha_pkg::entry_t            rentry,
  input  logic [NW-1:0]               rnext
);

  localparam int SW = ffha_pkg::SIZE_W;
  localparam int AW = ffha_pkg::ADDR_W;
  localparam logic [NW-1:0] LIST_END = NW'(MAX_BLOCKS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(MAX_BLOCKS - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CHK, S_SCAN, S_SPLIT, S_MRD, S_MCUR, S_MN, S_FIN
  } state_t;

  state_t          state;
  logic            is_release;
  logic [SW:0]     wanted;
  logic [AW-1:0]   target;
  logic [AW-1:0]   pos;
  logic [IW-1:0]   cur;
  logic [IW-1:0]   scan;
  logic [IW-1:0]   tslot;
  logic [SW-1:0]   c_size;
  logic            c_free;
  logic [NW-1:0]   c_next;
  logic [MAX_BLOCKS-1:0] slot_used;
  ffha_pkg::resp_t res;

  logic        accept;
  logic [SW:0] req_round;
  logic        fit, split_ok, hit, at_end, merge;
  logic [SW+1:0] split_need;
  logic [SW-1:0] msize;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign req_round = ({1'b0, in_data.request_bytes} + (SW+1)'(ffha_pkg::ALIGN_BYTES - 1))
                     & ~(SW+1)'(ffha_pkg::ALIGN_BYTES - 1);
  assign fit       = rentry.free && ({1'b0, rentry.size} >= wanted);
  assign split_need = {1'b0, wanted}
                      + (SW+2)'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES);
  assign split_ok  = {2'b00, rentry.size} >= split_need;
  assign hit       = (pos == target);
  assign at_end    = (rnext >= LIST_END);
  assign merge     = c_free && rentry.free;
  assign msize     = c_size + SW'(ffha_pkg::HEADER_BYTES) + rentry.size;

  // Memory port control.
  always_comb begin
    we     = 1'b0;
    waddr  = cur;
    wentry = rentry;
    wnext  = rnext;
    re     = 1'b0;
    raddr  = rnext[IW-1:0];
    case (state)
      S_INIT: begin
        we     = 1'b1;
        waddr  = '0;
        wentry = '{free: 1'b1, size: first_size};
        wnext  = LIST_END;
      end
      S_IDLE: begin
        raddr = '0;
        if (accept) begin
          if (in_data.action == ffha_pkg::ACTION_RELEASE) begin
            re = (in_data.payload_address != '0);
          end else begin
            re = (in_data.request_bytes != '0);
          end
        end
      end
      S_CHK: begin
        if (!is_release && fit) begin
          if (!split_ok) begin
            we     = 1'b1;
            wentry = '{free: 1'b0, size: rentry.size};
          end
        end else if (is_release && hit) begin
          we     = 1'b1;
          wentry = '{free: 1'b1, size: rentry.size};
        end else begin
          re = !at_end;
        end
      end
      S_SCAN: begin
        if (!slot_used[scan]) begin
          we     = 1'b1;
          waddr  = scan;
          wentry = '{free: 1'b1,
                     size: SW'(c_size - wanted[SW-1:0] - SW'(ffha_pkg::HEADER_BYTES))};
          wnext  = c_next;
        end else if (scan == LAST_SLOT) begin
          we     = 1'b1;
          wentry = '{free: 1'b0, size: c_size};
          wnext  = c_next;
        end
      end
      S_SPLIT: begin
        we     = 1'b1;
        wentry = '{free: 1'b0, size: wanted[SW-1:0]};
        wnext  = NW'(tslot);
      end
      S_MRD: begin
        re    = 1'b1;
        raddr = '0;
      end
      S_MCUR: begin
        re = !at_end;
      end
      S_MN: begin
        if (merge) begin
          we     = 1'b1;
          wentry = '{free: c_free, size: msize};
        end
        re = !at_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
      slot_used <= '0;
    end else begin
      // Load a finished item into the output register, or drop the one taken.
      if ((state == S_FIN) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (reinit) begin
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            slot_used <= MAX_BLOCKS'(1);
            state     <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) begin
              is_release <= (in_data.action == ffha_pkg::ACTION_RELEASE);
              wanted     <= req_round;
              target     <= in_data.payload_address;
              pos        <= start_addr + AW'(ffha_pkg::HEADER_BYTES);
              cur        <= '0;
              if (in_data.action == ffha_pkg::ACTION_RELEASE) begin
                res   <= '{granted_address: '0, status: ffha_pkg::STATUS_OK};
                state <= (in_data.payload_address != '0) ? S_CHK : S_FIN;
              end else if (in_data.request_bytes == '0) begin
                res   <= '{granted_address: '0, status: ffha_pkg::STATUS_NO_FIT};
                state <= S_FIN;
              end else begin
                res   <= '{granted_address: '0, status: ffha_pkg::STATUS_OK};
                state <= S_CHK;
              end
            end
          end
          S_CHK: begin
            c_size <= rentry.size;
            c_next <= rnext;
            if (!is_release && fit) begin
              res.granted_address <= pos;
              scan                <= '0;
              state               <= split_ok ? S_SCAN : S_FIN;
            end else if (is_release && hit) begin
              state <= S_MRD;
            end else begin
              pos <= pos + AW'(ffha_pkg::HEADER_BYTES) + AW'(rentry.size);
              cur <= rnext[IW-1:0];
              if (at_end) begin
                res.status <= is_release ? ffha_pkg::STATUS_UNKNOWN : ffha_pkg::STATUS_NO_FIT;
                state      <= S_FIN;
              end
            end
          end
          S_SCAN: begin
            if (!slot_used[scan]) begin
              slot_used[scan] <= 1'b1;
              tslot           <= scan;
              state           <= S_SPLIT;
            end else if (scan == LAST_SLOT) begin
              state <= S_FIN;
            end else begin
              scan <= scan + 1'b1;
            end
          end
          S_SPLIT: begin
            state <= S_FIN;
          end
          S_MRD: begin
            state <= S_MCUR;
          end
          S_MCUR: begin
            cur    <= '0;
            c_size <= rentry.size;
            c_free <= rentry.free;
            c_next <= rnext;
            state  <= at_end ? S_FIN : S_MN;
          end
          S_MN: begin
            // Merge the neighbor into cur, or step cur onto it.
            if (merge) begin
              c_size                      <= msize;
              slot_used[c_next[IW-1:0]]   <= 1'b0;
            end else begin
              cur    <= c_next[IW-1:0];
              c_size <= rentry.size;
              c_free <= rentry.free;
            end
            c_next <= rnext;
            if (at_end) begin
              state <= S_FIN;
            end
          end
          S_FIN: begin
            if (!out_valid || !out_stall) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

  `FFHA_ASSERT(a_busy_after_accept, clk, rst, accept |=> in_stall)
  `FFHA_NEVER(a_rw_same_entry, clk, rst, we && re && (waddr == raddr))
  `FFHA_ASSERT(a_result_from_fin, clk, rst,
               ($rose(out_valid) |-> $past(state) == S_FIN))
  `FFHA_NEVER(a_no_write_idle, clk, rst, (state == S_IDLE) && we)

endmodule

>>> design/first_fit_heap_allocator.sv
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+------------------------------
// in       | in  | in_valid / in_stall        | ffha_pkg::req_t
// out      | out | out_valid / out_stall      | ffha_pkg::resp_t
// apb      | in  | psel, penable, pwrite      | paddr[3:0], pwdata / prdata
//
// An item walks the block list in the block table RAM, one block at a time;
// a split also scans the table for an unused slot, and a release adds a
// merge pass over the whole list.
// rst is synchronous; after reset or any register write the INIT state
// rewrites table entry 0 before the next item is taken.
// A stalled result holds in the output register; the next item is accepted
// meanwhile, and its result waits until the register is free.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready,
  input  logic            in_valid,
  output logic            in_stall,
  input  ffha_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ffha_pkg::resp_t out_data
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int NW = $clog2(MAX_BLOCKS + 1);
  localparam int AW = ffha_pkg::ADDR_W;
  localparam int SW = ffha_pkg::SIZE_W;

  logic [AW-1:0] heap_base;
  logic [SW-1:0] heap_bytes;
  logic          cfg_write;
  logic [AW-1:0] start_addr;
  logic [SW-1:0] first_size;

  // Registers sit at 8-byte steps; bit 3 picks the register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= SW'(16 * 1024 * 1024);
    end else if (cfg_write) begin
      case (paddr[3])
        ffha_pkg::REG_HEAP_BASE:  heap_base  <= pwdata[AW-1:0];
        ffha_pkg::REG_HEAP_BYTES: heap_bytes <= pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      ffha_pkg::REG_HEAP_BASE:  prdata = {{(64-AW){1'b0}}, heap_base};
      ffha_pkg::REG_HEAP_BYTES: prdata = {{(64-SW){1'b0}}, heap_bytes};
      default:                  prdata = '0;
    endcase
  end

  // Round the base up to the alignment; first block gets what is left
  // after its header.
  assign start_addr = (heap_base + AW'(ffha_pkg::ALIGN_BYTES - 1))
                      & ~AW'(ffha_pkg::ALIGN_BYTES - 1);
  assign first_size = (heap_bytes > SW'(ffha_pkg::HEADER_BYTES))
                      ? heap_bytes - SW'(ffha_pkg::HEADER_BYTES) : '0;

  logic             we, re;
  logic [IW-1:0]    waddr, raddr;
  ffha_pkg::entry_t wentry, rentry;
  logic [NW-1:0]    wnext, rnext;

  ffha_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW), .NW(NW)) u_ctrl (
    .clk, .rst,
    .reinit(cfg_write),
    .start_addr, .first_size,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .we, .waddr, .wentry, .wnext,
    .re, .raddr, .rentry, .rnext
  );

  ffha_mem #(.MAX_BLOCKS(MAX_BLOCKS), .IW(IW), .NW(NW)) u_mem (
    .clk,
    .we, .waddr, .wentry, .wnext,
    .re, .raddr, .rentry, .rnext
  );

endmodule

>>> sim/heap_checker.sv
module heap_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [3:0]      paddr,
  input  logic [63:0]     pwdata,
  input  logic            in_valid,
  input  logic            in_stall,
  input  ffha_pkg::req_t  in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  ffha_pkg::resp_t out_data,
  output int              errors,
  output int              pending,
  output int              n_items,
  output int              n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MASK48   = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned MASK25   = 64'h1FF_FFFF;
  localparam int              NBLK     = ffha_pkg::MAX_BLOCKS;
  localparam int              LIST_END = ffha_pkg::MAX_BLOCKS;
  localparam longint unsigned HDR      = 64'(ffha_pkg::HEADER_BYTES);
  localparam longint unsigned ALIGN    = 64'(ffha_pkg::ALIGN_BYTES);

  longint unsigned heap_base_q, heap_bytes_q;
  longint unsigned blk_size [NBLK];
  bit              blk_free [NBLK];
  int              blk_next [NBLK];
  bit              blk_used [NBLK];
  ffha_pkg::resp_t grant_q[$];

  function automatic void rebuild_heap();
    for (int i = 0; i < NBLK; i++) begin
      blk_size[i] = 0;
      blk_free[i] = 0;
      blk_next[i] = 0;
      blk_used[i] = 0;
    end
    blk_used[0] = 1;
    blk_free[0] = 1;
    blk_next[0] = LIST_END;
    blk_size[0] = (heap_bytes_q > HDR) ? ((heap_bytes_q - HDR) & MASK25) : 64'd0;
  endfunction

  function automatic longint unsigned heap_start();
    return (((heap_base_q & MASK48) + ALIGN - 1) / ALIGN * ALIGN) & MASK48;
  endfunction

  function automatic ffha_pkg::resp_t predict_alloc(longint unsigned req);
    ffha_pkg::resp_t r;
    longint unsigned wanted, off, sz;
    int cur, spare;
    r.granted_address = '0;
    r.status = ffha_pkg::STATUS_NO_FIT;
    off = 0;
    cur = 0;
    if (req == 0) return r;
    wanted = (req + ALIGN - 1) / ALIGN * ALIGN;
    for (int steps = 0; steps < NBLK && cur < NBLK; steps++) begin
      sz = blk_size[cur];
      if (blk_free[cur] && sz >= wanted) begin
        if (sz >= wanted + HDR + ALIGN) begin
          // split only when a spare slot exists; a full table hands over the whole block
          spare = LIST_END;
          for (int i = NBLK - 1; i >= 0; i--)
            if (!blk_used[i]) spare = i;
          if (spare < NBLK) begin
            blk_used[spare] = 1;
            blk_free[spare] = 1;
            blk_size[spare] = (sz - wanted - HDR) & MASK25;
            blk_next[spare] = blk_next[cur];
            blk_next[cur]   = spare;
            blk_size[cur]   = wanted & MASK25;
          end
        end
        blk_free[cur] = 0;
        r.granted_address = ffha_pkg::ADDR_W'((heap_start() + off + HDR) & MASK48);
        r.status = ffha_pkg::STATUS_OK;
        return r;
      end
      off += HDR + sz;
      cur = blk_next[cur];
    end
    return r;
  endfunction

  function automatic void merge_adjacent();
    int cur, nxt;
    cur = 0;
    for (int guard = 0; guard < 2 * NBLK; guard++) begin
      nxt = blk_next[cur];
      if (nxt >= NBLK) break;
      if (blk_free[cur] && blk_free[nxt]) begin
        blk_size[cur] = (blk_size[cur] + HDR + blk_size[nxt]) & MASK25;
        blk_next[cur] = blk_next[nxt];
        blk_used[nxt] = 0;
        blk_free[nxt] = 0;
      end else begin
        cur = nxt;
      end
    end
  endfunction

  function automatic ffha_pkg::resp_t predict_release(longint unsigned addr);
    ffha_pkg::resp_t r;
    longint unsigned off;
    int cur;
    r.granted_address = '0;
    r.status = ffha_pkg::STATUS_OK;
    off = 0;
    cur = 0;
    if (addr == 0) return r;
    for (int steps = 0; steps < NBLK && cur < NBLK; steps++) begin
      if (((heap_start() + off + HDR) & MASK48) == addr) begin
        blk_free[cur] = 1;
        merge_adjacent();
        return r;
      end
      off += HDR + blk_size[cur];
      cur = blk_next[cur];
    end
    r.status = ffha_pkg::STATUS_UNKNOWN;
    return r;
  endfunction

  always @(posedge clk) begin
    ffha_pkg::resp_t want;
    int bad;
    bad = 0;
    if (rst) begin
      heap_base_q  = 0;
      heap_bytes_q = 16777216;
      rebuild_heap();
      grant_q.delete();
      errors    <= 0;
      n_items   <= 0;
      n_results <= 0;
    end else begin
      // any register write re-initializes the heap
      if (psel && penable && pwrite && pready) begin
        if (paddr[3] == ffha_pkg::REG_HEAP_BASE) begin
          heap_base_q = pwdata & MASK48;
          rebuild_heap();
        end else begin
          heap_bytes_q = pwdata & MASK25;
          rebuild_heap();
        end
      end
      if (in_valid && !in_stall) begin
        n_items <= n_items + 1;
        if (in_data.action == ffha_pkg::ACTION_ALLOC)
          grant_q.push_back(predict_alloc(64'(in_data.request_bytes)));
        else
          grant_q.push_back(predict_release(64'(in_data.payload_address)));
      end
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual addr=%h status=%0d",
                   $time, out_data.granted_address, out_data.status);
          bad++;
        end else begin
          want = grant_q.pop_front();
          if (out_data.granted_address !== want.granted_address) begin
            $display("%0t: granted_address mismatch: expected %h, actual %h",
                     $time, want.granted_address, out_data.granted_address);
            bad++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= grant_q.size();
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A worst-case item walks the whole list and then the merge pass.
  localparam int SETTLE_CYCLES = 2 * ffha_pkg::MAX_BLOCKS + 100;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam logic [3:0] ADDR_BASE  = {ffha_pkg::REG_HEAP_BASE, 3'b000};
  localparam logic [3:0] ADDR_BYTES = {ffha_pkg::REG_HEAP_BYTES, 3'b000};

  logic            clk;
  logic            rst;
  logic            psel, penable, pwrite;
  logic [3:0]      paddr;
  logic [63:0]     pwdata, prdata;
  logic            pready;
  logic            in_valid, in_stall;
  ffha_pkg::req_t  in_data;
  logic            out_valid, out_stall;
  ffha_pkg::resp_t out_data;

  int errors, pending, n_items, n_results;
  int send_idle_pct, stall_pct;
  int cycles = 0;
  logic [ffha_pkg::ADDR_W-1:0] live_addrs[$];

  first_fit_heap_allocator i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
  );

  heap_checker i_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .errors, .pending, .n_items, .n_results
  );

  initial begin
    clk = 0;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    in_data = '0;
    out_stall = 0;
    send_idle_pct = 0;
    stall_pct = 0;
  end

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Random receiver back-pressure at the rate of the current phase.
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Remember granted addresses so that releases can hit real blocks.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && out_data.status == ffha_pkg::STATUS_OK &&
        out_data.granted_address != 0)
      live_addrs.push_back(out_data.granted_address);
  end

  // Watchdog on a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Present one item, hold it until accepted, then idle at random.
  task automatic send_item(ffha_pkg::req_t item);
    in_valid <= 1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  // Drop valid and hold until every expected result is back and the block settles.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the access edge.
  task automatic write_reg(logic [3:0] addr, logic [63:0] value);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
    live_addrs.delete();
  endtask

  task automatic set_heap(logic [47:0] base, logic [24:0] bytes);
    drain();
    write_reg(ADDR_BASE, 64'(base));
    write_reg(ADDR_BYTES, 64'(bytes));
  endtask

  function automatic ffha_pkg::req_t alloc_item(logic [24:0] bytes);
    ffha_pkg::req_t r;
    r.action          = ffha_pkg::ACTION_ALLOC;
    r.request_bytes   = bytes;
    r.payload_address = 48'({$urandom, $urandom});
    return r;
  endfunction

  function automatic ffha_pkg::req_t release_item(logic [47:0] addr);
    ffha_pkg::req_t r;
    r.action          = ffha_pkg::ACTION_RELEASE;
    r.request_bytes   = 25'($urandom);
    r.payload_address = addr;
    return r;
  endfunction

  // Mostly small allocations and releases of live blocks; some junk on top.
  function automatic ffha_pkg::req_t random_item(int alloc_pct);
    int pick, k;
    logic [47:0] addr;
    pick = $urandom_range(99);
    if (pick < alloc_pct || live_addrs.size() == 0 && pick < 90) begin
      pick = $urandom_range(99);
      if (pick < 70)      return alloc_item(25'($urandom_range(64, 1)));
      else if (pick < 90) return alloc_item(25'($urandom_range(4096, 1)));
      else if (pick < 96) return alloc_item(25'd0);
      else                return alloc_item(25'($urandom));
    end
    pick = $urandom_range(99);
    if (pick < 75 && live_addrs.size() != 0) begin
      k = $urandom_range(live_addrs.size() - 1);
      addr = live_addrs[k];
      // keep a few around so that double releases happen
      if ($urandom_range(9) != 0) live_addrs.delete(k);
      return release_item(addr);
    end
    if (pick < 85) return release_item('0);
    if (live_addrs.size() != 0 && pick < 92)
      return release_item(live_addrs[$urandom_range(live_addrs.size() - 1)] + 48'd16);
    return release_item(48'({$urandom, $urandom}));
  endfunction

  task automatic random_phase(int count, int alloc_pct, int idle, int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < count; i++) begin
      send_item(random_item(alloc_pct));
      // once per phase stop and wait for everything to come back
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    logic [47:0] first_addr, second_addr;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: default heap at address 0, full 16 MiB.
    send_item(alloc_item(25'd0));
    send_item(alloc_item(25'd1));
    send_item(alloc_item(25'd16));
    send_item(alloc_item(25'd17));
    send_item(alloc_item(25'd16777216));
    send_item(alloc_item(25'h1FF_FFFF));
    send_item(release_item('0));
    send_item(release_item(48'd1));
    send_item(release_item(48'hFFFF_FFFF_FFFF));
    drain();
    first_addr  = live_addrs[0];
    second_addr = live_addrs[1];
    send_item(release_item(first_addr));
    send_item(release_item(first_addr));
    send_item(release_item(second_addr));
    send_item(alloc_item(25'd16777216 - 25'(ffha_pkg::HEADER_BYTES)));
    send_item(alloc_item(25'd48));
    send_item(alloc_item(25'd32));

    // Tiny heap below one header: nothing ever fits.
    set_heap(48'h0000_0000_0007, 25'd16);
    send_item(alloc_item(25'd1));
    send_item(release_item(48'd24));
    send_item(release_item(48'd40));

    // Heap at the top of the address space: payload addresses wrap.
    set_heap(48'hFFFF_FFFF_FFF0, 25'd4096);
    send_item(alloc_item(25'd16));
    send_item(alloc_item(25'd4000));
    send_item(alloc_item(25'(4096 - 2 * ffha_pkg::HEADER_BYTES - 16)));
    drain();
    if (live_addrs.size() != 0) send_item(release_item(live_addrs[0]));

    random_phase(75, 60, 79, 0);

    set_heap(48'({$urandom, $urandom}), 25'h1FF_FFFF);
    random_phase(75, 55, 0, 79);

    set_heap(48'({$urandom, $urandom}), 25'($urandom_range(16777216, 4096)));
    random_phase(75, 55, 35, 35);

    // Fill the block table until splitting stops, then keep going.
    set_heap('0, 25'd16777216);
    random_phase(290, 97, 0, 0);

    drain();
    $display("covered %0d items and %0d results over tiny, wrapped, small and full heaps",
             n_items, n_results);
    $display("all four idle/stall mixes run; block table driven past %0d slots",
             ffha_pkg::MAX_BLOCKS - 1);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
